// ----- src/ghva_pkg.sv -----
// Package: shared types, constants and command structs for the Hough vote accumulator.
package ghva_pkg;
	localparam int NUM_MAPS_DEF = 32;
	localparam int GRID_MAX_DEF = 32;
	localparam int CFG_W = 16;
	localparam int CFG_IDX_W = 3;
	localparam int CELL_W = 32;

	typedef enum logic [1:0] {
		KIND_CLEAR = 2'd0,
		KIND_VOTE  = 2'd1,
		KIND_QUERY = 2'd2,
		KIND_NONE  = 2'd3
	} kind_t;

	typedef enum logic [2:0] {
		REG_GRID_STEP     = 3'd0,
		REG_WEIGHT_CENTER = 3'd1,
		REG_WEIGHT_EDGE1  = 3'd2,
		REG_WEIGHT_DIAG1  = 3'd3,
		REG_WEIGHT_EDGE2  = 3'd4,
		REG_WEIGHT_KNIGHT = 3'd5,
		REG_WEIGHT_CORNER = 3'd6,
		REG_BURST_LIMIT   = 3'd7
	} reg_idx_t;

	typedef enum logic [3:0] {
		ST_CLR,
		ST_IDLE,
		ST_QX,
		ST_DIVWAIT,
		ST_VPREP,
		ST_VRD,
		ST_VWAIT,
		ST_VWR,
		ST_QRD,
		ST_QWAIT,
		ST_QSCAN,
		ST_QDONE,
		ST_OUT
	} state_t;

	typedef struct packed {
		logic load;
		logic clr_start;
		logic clr_step;
		logic div_start;
		logic div_sel_y;
		logic vote_init;
		logic win_rd;
		logic win_wr;
		logic win_next;
		logic scan_init;
		logic scan_rd;
		logic scan_cmp;
		logic out_set;
		logic out_bad;
	} cmd_t;

	typedef struct packed {
		kind_t kind;
		logic  map_ok;
		logic  vote_ok;
		logic  clr_last;
		logic  div_done;
		logic  win_last;
		logic  win_in;
		logic  scan_last;
		logic  scan_pend;
	} sts_t;
endpackage

// ----- src/ghva_divider.sv -----
// Signed floor divider by a positive 12-bit divisor, one quotient bit per cycle.
module ghva_divider #(
	parameter int NW = 26
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	input  logic signed [NW-1:0] num,
	input  logic [11:0]          den,
	output logic                 done,
	output logic signed [NW-1:0] quo
);
	localparam int CW = $clog2(NW + 1);
	logic [NW-1:0] mag_q, quo_q;
	logic [12:0]   rem_q;
	logic [11:0]   den_q;
	logic          neg_q, busy_q;
	logic [CW-1:0] cnt_q;
	logic [12:0]   trial;
	logic [13:0]   diff;

	assign trial = {rem_q[11:0], mag_q[NW-1]};
	assign diff  = {1'b0, trial} - {2'b00, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done   <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CW'(NW);
			end else if (busy_q) begin
				cnt_q <= cnt_q - CW'(1);
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
					done   <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			neg_q <= num[NW-1];
			mag_q <= num[NW-1] ? (~num) : num;
			den_q <= den;
			rem_q <= '0;
			quo_q <= '0;
		end else if (busy_q) begin
			mag_q <= {mag_q[NW-2:0], 1'b0};
			if (!diff[13]) begin
				rem_q <= diff[12:0];
				quo_q <= {quo_q[NW-2:0], 1'b1};
			end else begin
				rem_q <= trial;
				quo_q <= {quo_q[NW-2:0], 1'b0};
			end
		end
	end

	// negative numerator handled as ~n = -n-1: floor(n/d) = -(floor((-n-1)/d)) - 1
	assign quo = neg_q ? $signed(~quo_q) : $signed(quo_q);
endmodule

// ----- src/ghva_datapath.sv -----
// Datapath: registers, input hold, quantizer, window walker, vote memory and scan.
module ghva_datapath #(
	parameter int NUM_MAPS = ghva_pkg::NUM_MAPS_DEF,
	parameter int GRID_MAX = ghva_pkg::GRID_MAX_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_we,
	input  logic [ghva_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [ghva_pkg::CFG_W-1:0]  cfg_data,
	input  logic [1:0]                  kind,
	input  logic [4:0]                  map_index,
	input  logic [11:0]                 key_x,
	input  logic [11:0]                 key_y,
	input  logic signed [17:0]          offset_x,
	input  logic signed [17:0]          offset_y,
	input  logic [11:0]                 logo_width,
	input  logic [11:0]                 logo_height,
	input  logic [15:0]                 word_weight,
	input  logic [7:0]                  obj_word_count,
	input  logic [7:0]                  logo_word_count,
	input  ghva_pkg::cmd_t              cmd,
	output ghva_pkg::sts_t              sts,
	output logic [31:0]                 best_score,
	output logic [4:0]                  best_row,
	output logic [4:0]                  best_col,
	output logic                        found
);
	localparam int GW = $clog2(GRID_MAX);
	localparam int MW = (NUM_MAPS > 1) ? $clog2(NUM_MAPS) : 1;
	localparam int AW = MW + 2 * GW;
	localparam int DEPTH = 1 << AW;
	localparam int SW = $clog2(GRID_MAX + 1);
	localparam int NW = 26;
	localparam int QW = 10;
	localparam logic signed [NW-1:0] Q_LO = NW'(-4);
	localparam logic signed [NW-1:0] Q_HI = NW'(GRID_MAX + 4);

	logic [5:0]  grid_step_q;
	logic [15:0] w_q [6];
	logic [15:0] burst_limit_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			grid_step_q   <= 6'd32;
			w_q[0]        <= 16'hFFFF;
			w_q[1]        <= '0;
			w_q[2]        <= '0;
			w_q[3]        <= '0;
			w_q[4]        <= '0;
			w_q[5]        <= '0;
			burst_limit_q <= 16'd10;
		end else if (cfg_we) begin
			unique case (ghva_pkg::reg_idx_t'(cfg_index))
				ghva_pkg::REG_GRID_STEP:     grid_step_q   <= cfg_data[5:0];
				ghva_pkg::REG_WEIGHT_CENTER: w_q[0]        <= cfg_data;
				ghva_pkg::REG_WEIGHT_EDGE1:  w_q[1]        <= cfg_data;
				ghva_pkg::REG_WEIGHT_DIAG1:  w_q[2]        <= cfg_data;
				ghva_pkg::REG_WEIGHT_EDGE2:  w_q[3]        <= cfg_data;
				ghva_pkg::REG_WEIGHT_KNIGHT: w_q[4]        <= cfg_data;
				ghva_pkg::REG_WEIGHT_CORNER: w_q[5]        <= cfg_data;
				ghva_pkg::REG_BURST_LIMIT:   burst_limit_q <= cfg_data;
			endcase
		end
	end

	logic [SW-1:0] step;
	assign step = (32'(grid_step_q) > 32'(GRID_MAX)) ? SW'(GRID_MAX) : SW'(grid_step_q);

	// hold item
	logic [1:0]  kind_q;
	logic [4:0]  map_q;
	logic [11:0] kx_q, ky_q, lw_q, lh_q;
	logic signed [17:0] ox_q, oy_q;
	logic [31:0] score_q;
	logic        wc_ok_q;
	logic [15:0] wcount;
	assign wcount = 16'(obj_word_count) * 16'(logo_word_count);

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			kind_q  <= kind;
			map_q   <= map_index;
			kx_q    <= key_x;
			ky_q    <= key_y;
			ox_q    <= offset_x;
			oy_q    <= offset_y;
			lw_q    <= (logo_width == 12'd0) ? 12'd1 : logo_width;
			lh_q    <= (logo_height == 12'd0) ? 12'd1 : logo_height;
			score_q <= 32'(word_weight) * 32'(word_weight);
			wc_ok_q <= (wcount <= burst_limit_q);
		end
	end

	// quantizer: center = (16k - off + 8) >>> 4, then floor(center*step/size)
	logic signed [19:0] c16;
	logic signed [15:0] center;
	logic signed [NW-1:0] prod;
	logic div_done;
	logic signed [NW-1:0] quo;
	logic signed [QW-1:0] quo_c;
	logic signed [QW-1:0] qx_q, qy_q;

	always_comb begin
		if (cmd.div_sel_y)
			c16 = $signed({4'b0, ky_q, 4'b0}) - 20'(oy_q) + 20'sd8;
		else
			c16 = $signed({4'b0, kx_q, 4'b0}) - 20'(ox_q) + 20'sd8;
		center = c16[19:4];
		prod   = NW'(center) * NW'($signed({1'b0, step}));
	end

	ghva_divider #(.NW(NW)) u_div (
		.clk(clk), .arst_n(arst_n), .start(cmd.div_start), .num(prod),
		.den(cmd.div_sel_y ? lh_q : lw_q), .done(div_done), .quo(quo)
	);

	// clamp far off-grid centers so the window stays off-grid
	assign quo_c = (quo < Q_LO) ? QW'(Q_LO) : ((quo > Q_HI) ? QW'(Q_HI) : QW'(quo));

	always_ff @(posedge clk) begin
		if (div_done) begin
			if (cmd.div_sel_y) qy_q <= quo_c;
			else qx_q <= quo_c;
		end
	end

	// window walker
	logic [2:0] wr_q, wc_q;
	logic signed [QW:0] r_abs, c_abs;
	logic win_in;
	logic [2:0] adr, adc;
	logic [15:0] wsel;
	assign r_abs = {qy_q[QW-1], qy_q} + (QW+1)'(wr_q) - (QW+1)'(2);
	assign c_abs = {qx_q[QW-1], qx_q} + (QW+1)'(wc_q) - (QW+1)'(2);
	assign win_in = !r_abs[QW] && !c_abs[QW] && (r_abs < (QW+1)'(step))
		&& (c_abs < (QW+1)'(step));
	assign adr = (wr_q >= 3'd2) ? wr_q - 3'd2 : 3'd2 - wr_q;
	assign adc = (wc_q >= 3'd2) ? wc_q - 3'd2 : 3'd2 - wc_q;

	always_comb begin
		unique case ({adr[1:0], adc[1:0]})
			4'b0000:          wsel = w_q[0];
			4'b0001, 4'b0100: wsel = w_q[1];
			4'b0101:          wsel = w_q[2];
			4'b0010, 4'b1000: wsel = w_q[3];
			4'b0110, 4'b1001: wsel = w_q[4];
			default:          wsel = w_q[5];
		endcase
	end

	always_ff @(posedge clk) begin
		if (cmd.vote_init) begin
			wr_q <= '0;
			wc_q <= '0;
		end else if (cmd.win_next) begin
			if (wc_q == 3'd4) begin
				wc_q <= '0;
				wr_q <= wr_q + 3'd1;
			end else begin
				wc_q <= wc_q + 3'd1;
			end
		end
	end

	logic [47:0] add_s1;
	always_ff @(posedge clk) begin
		if (cmd.win_rd) add_s1 <= 48'(score_q) * 48'(wsel);
	end
	logic [32:0] add_r;
	assign add_r = 33'((add_s1 + 48'h8000) >> 16);

	// memory with clear sweep
	logic [31:0] mem [DEPTH];
	logic [AW-1:0] clr_a_q, scan_a_q, rd_a, vwa;
	logic [31:0] rd_d;
	logic mem_we;
	logic [AW-1:0] mem_wa;
	logic [31:0] mem_wd;
	logic [32:0] sum;

	assign vwa = {MW'(map_q), GW'(r_abs), GW'(c_abs)};
	assign rd_a = cmd.scan_rd ? scan_a_q : vwa;
	assign sum = 33'(rd_d) + add_r;

	always_comb begin
		mem_we = cmd.clr_step || cmd.win_wr;
		mem_wa = cmd.clr_step ? clr_a_q : vwa;
		mem_wd = cmd.clr_step ? 32'd0 : (sum[32] ? 32'hFFFF_FFFF : sum[31:0]);
	end

	always_ff @(posedge clk) begin
		if (mem_we) mem[mem_wa] <= mem_wd;
		rd_d <= mem[rd_a];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) clr_a_q <= '0;
		else if (cmd.clr_start) clr_a_q <= '0;
		else if (cmd.clr_step) clr_a_q <= clr_a_q + AW'(1);
	end

	// scan: address register advances with reads, compare uses previous read
	logic [2*GW-1:0] cmp_pos_s1;
	logic scan_pend_q;
	logic [31:0] best_q;
	logic [2*GW-1:0] bpos_q;
	always_ff @(posedge clk) begin
		if (cmd.scan_init) begin
			scan_a_q <= {MW'(map_q), (2*GW)'(0)};
			best_q   <= '0;
			bpos_q   <= '0;
		end else begin
			if (cmd.scan_rd) begin
				scan_a_q   <= scan_a_q + AW'(1);
				cmp_pos_s1 <= scan_a_q[2*GW-1:0];
			end
			if (cmd.scan_cmp && scan_pend_q && rd_d > best_q) begin
				best_q <= rd_d;
				bpos_q <= cmp_pos_s1;
			end
		end
	end
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) scan_pend_q <= 1'b0;
		else scan_pend_q <= cmd.scan_rd;
	end

	always_ff @(posedge clk) begin
		if (cmd.out_set) begin
			if (cmd.out_bad) begin
				best_score <= '0;
				best_row   <= '0;
				best_col   <= '0;
				found      <= 1'b0;
			end else begin
				best_score <= best_q;
				best_row   <= 5'(bpos_q[2*GW-1:GW]);
				best_col   <= 5'(bpos_q[GW-1:0]);
				found      <= (best_q != 32'd0);
			end
		end
	end

	always_comb begin
		sts.kind      = ghva_pkg::kind_t'(kind_q);
		sts.map_ok    = (32'(map_q) < 32'(NUM_MAPS));
		sts.vote_ok   = wc_ok_q && sts.map_ok;
		sts.clr_last  = (clr_a_q == AW'(DEPTH - 1));
		sts.div_done  = div_done;
		sts.win_last  = (wr_q == 3'd4) && (wc_q == 3'd4);
		sts.win_in    = win_in;
		sts.scan_last = (scan_a_q[2*GW-1:0] == {(2*GW){1'b1}});
		sts.scan_pend = scan_pend_q;
	end
endmodule

// ----- src/ghva_ctrl.sv -----
// Controller: sequences clear sweep, vote window updates and grid scan.
module ghva_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_stall,
	output logic           out_valid,
	input  logic           out_stall,
	input  ghva_pkg::sts_t sts,
	output ghva_pkg::cmd_t cmd
);
	ghva_pkg::state_t st_q, st_d;
	logic sel_y_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q    <= ghva_pkg::ST_CLR;
			sel_y_q <= 1'b0;
		end else begin
			st_q <= st_d;
			if (st_q == ghva_pkg::ST_VPREP) sel_y_q <= 1'b0;
			else if (st_q == ghva_pkg::ST_DIVWAIT && sts.div_done) sel_y_q <= 1'b1;
		end
	end

	logic acc;
	assign acc = in_valid && !in_stall;

	always_comb begin
		st_d = st_q;
		unique case (st_q)
			ghva_pkg::ST_CLR: if (sts.clr_last) st_d = ghva_pkg::ST_IDLE;
			ghva_pkg::ST_IDLE: if (acc) st_d = ghva_pkg::ST_VPREP;
			ghva_pkg::ST_VPREP: begin
				unique case (sts.kind)
					ghva_pkg::KIND_CLEAR: st_d = ghva_pkg::ST_CLR;
					ghva_pkg::KIND_VOTE:
						st_d = sts.vote_ok ? ghva_pkg::ST_QX : ghva_pkg::ST_IDLE;
					ghva_pkg::KIND_QUERY:
						st_d = sts.map_ok ? ghva_pkg::ST_QRD : ghva_pkg::ST_QDONE;
					default: st_d = ghva_pkg::ST_IDLE;
				endcase
			end
			ghva_pkg::ST_QX: st_d = ghva_pkg::ST_DIVWAIT;
			ghva_pkg::ST_DIVWAIT: if (sts.div_done)
				st_d = sel_y_q ? ghva_pkg::ST_VRD : ghva_pkg::ST_QX;
			ghva_pkg::ST_VRD: st_d = sts.win_in ? ghva_pkg::ST_VWAIT :
				(sts.win_last ? ghva_pkg::ST_IDLE : ghva_pkg::ST_VRD);
			ghva_pkg::ST_VWAIT: st_d = ghva_pkg::ST_VWR;
			ghva_pkg::ST_VWR: st_d = sts.win_last ? ghva_pkg::ST_IDLE : ghva_pkg::ST_VRD;
			ghva_pkg::ST_QRD: if (sts.scan_last) st_d = ghva_pkg::ST_QWAIT;
			ghva_pkg::ST_QWAIT: st_d = ghva_pkg::ST_QSCAN;
			ghva_pkg::ST_QSCAN: st_d = ghva_pkg::ST_QDONE;
			ghva_pkg::ST_QDONE: st_d = ghva_pkg::ST_OUT;
			ghva_pkg::ST_OUT: if (!out_stall) st_d = ghva_pkg::ST_IDLE;
			default: st_d = ghva_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		cmd = '0;
		in_stall  = (st_q != ghva_pkg::ST_IDLE);
		out_valid = (st_q == ghva_pkg::ST_OUT);
		cmd.div_sel_y = sel_y_q;
		unique case (st_q)
			ghva_pkg::ST_CLR: cmd.clr_step = 1'b1;
			ghva_pkg::ST_IDLE: cmd.load = acc;
			ghva_pkg::ST_VPREP: begin
				cmd.vote_init = 1'b1;
				cmd.scan_init = 1'b1;
				cmd.clr_start = (sts.kind == ghva_pkg::KIND_CLEAR);
			end
			ghva_pkg::ST_QX: cmd.div_start = 1'b1;
			ghva_pkg::ST_VRD: begin
				cmd.win_rd   = 1'b1;
				cmd.win_next = !sts.win_in;
			end
			ghva_pkg::ST_VWR: begin
				cmd.win_wr   = 1'b1;
				cmd.win_next = 1'b1;
			end
			ghva_pkg::ST_QRD: begin
				cmd.scan_rd  = 1'b1;
				cmd.scan_cmp = 1'b1;
			end
			ghva_pkg::ST_QWAIT: cmd.scan_cmp = 1'b1;
			ghva_pkg::ST_QDONE: begin
				cmd.out_set = 1'b1;
				cmd.out_bad = !sts.map_ok;
			end
			default: ;
		endcase
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid)
		else $error("result dropped under stall");
	assert property (@(posedge clk) disable iff (!arst_n)
		cmd.win_wr |-> !cmd.clr_step)
		else $error("vote write during clear");
	assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load |=> in_stall)
		else $error("second item taken while busy");
endmodule

// ----- src/gaussian_hough_vote_accumulator_top.sv -----
// Top level: Gaussian-weighted Hough vote accumulator.
// Input channel (in_valid/in_stall) takes clear, vote and query items one at a
// time; in_stall is high whenever an item is in work. Output channel
// (out_valid/out_stall) carries one result per query; the result is held while
// out_stall is high and the next item is taken after it transfers.
// Configuration writes go through cfg_we/cfg_index/cfg_data; the user must
// make them only while idle, since the block itself does not enforce it.
// Steps after an input transfer, until in_stall drops again:
//   vote:  setup, then the x and then the y quantizer division on the serial
//          divider (one quotient bit per cycle), then read, wait and write
//          for each in-grid window cell and a read only for each off-grid
//          cell; a dropped vote ends after setup.
//   query: setup, GRID_MAX*GRID_MAX memory reads, one per cycle, the final
//          compares and the result update; the result is then offered and
//          held until it transfers (no reads for an out-of-range map).
//   clear: setup, then one cell write per cycle over the whole memory.
// After reset the same clearing pass runs and no item is accepted until it
// ends. The serial divider and the one-read, one-write memory set the pace.
module gaussian_hough_vote_accumulator_top #(
	parameter int NUM_MAPS = ghva_pkg::NUM_MAPS_DEF,
	parameter int GRID_MAX = ghva_pkg::GRID_MAX_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [ghva_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [ghva_pkg::CFG_W-1:0]     cfg_data,
	input  logic                           in_valid,
	output logic                           in_stall,
	input  logic [1:0]                     kind,
	input  logic [4:0]                     map_index,
	input  logic [11:0]                    key_x,
	input  logic [11:0]                    key_y,
	input  logic signed [17:0]             offset_x,
	input  logic signed [17:0]             offset_y,
	input  logic [11:0]                    logo_width,
	input  logic [11:0]                    logo_height,
	input  logic [15:0]                    word_weight,
	input  logic [7:0]                     obj_word_count,
	input  logic [7:0]                     logo_word_count,
	output logic                           out_valid,
	input  logic                           out_stall,
	output logic [31:0]                    best_score,
	output logic [4:0]                     best_row,
	output logic [4:0]                     best_col,
	output logic                           found
);
	ghva_pkg::cmd_t cmd;
	ghva_pkg::sts_t sts;

	ghva_datapath #(.NUM_MAPS(NUM_MAPS), .GRID_MAX(GRID_MAX)) u_dp (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
		.cfg_data(cfg_data), .kind(kind), .map_index(map_index), .key_x(key_x),
		.key_y(key_y), .offset_x(offset_x), .offset_y(offset_y),
		.logo_width(logo_width), .logo_height(logo_height),
		.word_weight(word_weight), .obj_word_count(obj_word_count),
		.logo_word_count(logo_word_count), .cmd(cmd), .sts(sts),
		.best_score(best_score), .best_row(best_row), .best_col(best_col),
		.found(found)
	);

	ghva_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_stall(in_stall),
		.out_valid(out_valid), .out_stall(out_stall), .sts(sts), .cmd(cmd)
	);
endmodule

// ----- bench/ghva_checker.sv -----
// Checker: predicts vote grid contents and query results, compares each result transfer.
module ghva_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [15:0] cfg_data,
	input  logic        in_valid,
	input  logic        in_stall,
	input  logic [1:0]  kind,
	input  logic [4:0]  map_index,
	input  logic [11:0] key_x,
	input  logic [11:0] key_y,
	input  logic signed [17:0] offset_x,
	input  logic signed [17:0] offset_y,
	input  logic [11:0] logo_width,
	input  logic [11:0] logo_height,
	input  logic [15:0] word_weight,
	input  logic [7:0]  obj_word_count,
	input  logic [7:0]  logo_word_count,
	input  logic        out_valid,
	input  logic        out_stall,
	input  logic [31:0] best_score,
	input  logic [4:0]  best_row,
	input  logic [4:0]  best_col,
	input  logic        found,
	output int          fail_count,
	output int          pending
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam int MAPS = ghva_pkg::NUM_MAPS_DEF;
	localparam int GMAX = ghva_pkg::GRID_MAX_DEF;

	typedef struct packed {
		logic [31:0] score;
		logic [4:0]  row;
		logic [4:0]  col;
		logic        hit;
	} peak_t;

	logic [31:0] grid_cells [MAPS*GMAX*GMAX];
	logic [5:0]  step_reg;
	logic [15:0] wt_reg [7];
	logic [15:0] burst_reg;
	peak_t       peak_q [$];

	function automatic longint floor_div(longint n, longint d);
		if (n >= 0)
			return n / d;
		return -((-n + d - 1) / d);
	endfunction

	function automatic longint grid_coord(logic [11:0] key, logic signed [17:0] off,
			logic [11:0] size, longint step);
		longint c16, center, sz;
		c16 = longint'(key) * 16 - longint'(off);
		center = floor_div(c16 + 8, 16);
		sz = (size == 0) ? 1 : longint'(size);
		return floor_div(center * step, sz);
	endfunction

	function automatic logic [15:0] ring_weight(longint dy, longint dx);
		case (dy * dy + dx * dx)
			0: return wt_reg[ghva_pkg::REG_WEIGHT_CENTER];
			1: return wt_reg[ghva_pkg::REG_WEIGHT_EDGE1];
			2: return wt_reg[ghva_pkg::REG_WEIGHT_DIAG1];
			4: return wt_reg[ghva_pkg::REG_WEIGHT_EDGE2];
			5: return wt_reg[ghva_pkg::REG_WEIGHT_KNIGHT];
			default: return wt_reg[ghva_pkg::REG_WEIGHT_CORNER];
		endcase
	endfunction

	task automatic spread_vote();
		longint step, qx, qy, idx;
		logic [63:0] idf2, add, sum;
		if (longint'(obj_word_count) * longint'(logo_word_count) > longint'(burst_reg))
			return;
		step = (step_reg > GMAX) ? GMAX : step_reg;
		idf2 = 64'(word_weight) * 64'(word_weight);
		qx = grid_coord(key_x, offset_x, logo_width, step);
		qy = grid_coord(key_y, offset_y, logo_height, step);
		for (longint r = qy - 2; r <= qy + 2; r++) begin
			for (longint c = qx - 2; c <= qx + 2; c++) begin
				if (r < 0 || r >= step || c < 0 || c >= step)
					continue;
				add = (idf2 * 64'(ring_weight(r - qy, c - qx)) + 64'h8000) >> 16;
				idx = longint'(map_index) * GMAX * GMAX + r * GMAX + c;
				sum = 64'(grid_cells[idx]) + add;
				grid_cells[idx] = (sum > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : sum[31:0];
			end
		end
	endtask

	function automatic peak_t find_peak(logic [4:0] m);
		peak_t p;
		logic [31:0] v;
		p = '0;
		for (int r = 0; r < GMAX; r++) begin
			for (int c = 0; c < GMAX; c++) begin
				v = grid_cells[m * GMAX * GMAX + r * GMAX + c];
				if (v > p.score) begin
					p.score = v;
					p.row = r[4:0];
					p.col = c[4:0];
					p.hit = 1'b1;
				end
			end
		end
		return p;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		peak_t exp_p, pred_p;
		if (!arst_n) begin
			foreach (grid_cells[i])
				grid_cells[i] = '0;
			step_reg = 6'd32;
			foreach (wt_reg[i])
				wt_reg[i] = '0;
			wt_reg[ghva_pkg::REG_WEIGHT_CENTER] = 16'hFFFF;
			burst_reg = 16'd10;
			peak_q.delete();
			fail_count = 0;
			pending = 0;
		end else begin
			if (out_valid && !out_stall) begin
				if (peak_q.size() == 0) begin
					$display("%0t: result with nothing expected: score %h row %0d col %0d found %b",
						$time, best_score, best_row, best_col, found);
					fail_count++;
				end else begin
					exp_p = peak_q.pop_front();
					if (best_score !== exp_p.score || best_row !== exp_p.row ||
							best_col !== exp_p.col || found !== exp_p.hit) begin
						$display("%0t: mismatch: expected score %h row %0d col %0d found %b,",
							$time, exp_p.score, exp_p.row, exp_p.col, exp_p.hit);
						$display("    actual score %h row %0d col %0d found %b",
							best_score, best_row, best_col, found);
						fail_count++;
					end
				end
			end
			if (cfg_we) begin
				case (ghva_pkg::reg_idx_t'(cfg_index))
					ghva_pkg::REG_GRID_STEP: step_reg = cfg_data[5:0];
					ghva_pkg::REG_BURST_LIMIT: burst_reg = cfg_data;
					default: wt_reg[cfg_index] = cfg_data;
				endcase
			end
			if (in_valid && !in_stall) begin
				case (ghva_pkg::kind_t'(kind))
					ghva_pkg::KIND_CLEAR: foreach (grid_cells[i]) grid_cells[i] = '0;
					ghva_pkg::KIND_VOTE: if (map_index < MAPS) spread_vote();
					ghva_pkg::KIND_QUERY: begin
						pred_p = '0;
						if (map_index < MAPS)
							pred_p = find_peak(map_index);
						peak_q = {peak_q, pred_p};
					end
					default: ;
				endcase
			end
			pending = peak_q.size();
		end
	end
endmodule

// ----- bench/testbench.sv -----
// Testbench top: drives configuration, vote, clear and query items and gives the verdict.
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_we = 1'b0;
	logic [2:0]  cfg_index = '0;
	logic [15:0] cfg_data = '0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic [1:0]  kind = '0;
	logic [4:0]  map_index = '0;
	logic [11:0] key_x = '0, key_y = '0;
	logic signed [17:0] offset_x = '0, offset_y = '0;
	logic [11:0] logo_width = 12'd1, logo_height = 12'd1;
	logic [15:0] word_weight = '0;
	logic [7:0]  obj_word_count = '0, logo_word_count = '0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [31:0] best_score;
	logic [4:0]  best_row, best_col;
	logic        found;
	int          fail_count, pending;
	longint      cycles = 0;
	bit          hold_rx = 1'b0;
	bit          rx_hold_done = 1'b0;

	always #6 clk = ~clk;

	gaussian_hough_vote_accumulator_top dut (.*);
	ghva_checker chk (.*);

	task automatic write_reg(ghva_pkg::reg_idx_t idx, logic [15:0] val);
		@(negedge clk);
		cfg_we = 1'b1;
		cfg_index = idx;
		cfg_data = val;
		@(negedge clk);
		cfg_we = 1'b0;
	endtask

	task automatic drain();
		while (pending != 0 || in_stall)
			@(negedge clk);
		repeat (200) @(negedge clk);
	endtask

	task automatic random_gap();
		int g;
		g = ($urandom_range(0, 9) < 6) ? 0 :
			($urandom_range(0, 19) == 0) ? $urandom_range(20, 120) : $urandom_range(1, 4);
		repeat (g) @(negedge clk);
	endtask

	task automatic send(ghva_pkg::kind_t k, logic [4:0] m, logic [11:0] kx, logic [11:0] ky,
			logic signed [17:0] ox, logic signed [17:0] oy, logic [11:0] lw,
			logic [11:0] lh, logic [15:0] ww, logic [7:0] oc, logic [7:0] lc);
		kind = k;
		map_index = m;
		key_x = kx;
		key_y = ky;
		offset_x = ox;
		offset_y = oy;
		logo_width = lw;
		logo_height = lh;
		word_weight = ww;
		obj_word_count = oc;
		logo_word_count = lc;
		in_valid = 1'b1;
		do @(posedge clk); while (in_stall);
		@(negedge clk);
		in_valid = 1'b0;
		random_gap();
	endtask

	task automatic random_vote(logic [4:0] m);
		logic [11:0] lw, lh, kx, ky;
		lw = ($urandom_range(0, 9) == 0) ? 12'($urandom) : 12'($urandom_range(16, 600));
		lh = ($urandom_range(0, 9) == 0) ? 12'($urandom) : 12'($urandom_range(16, 600));
		kx = ($urandom_range(0, 9) == 0) ? 12'($urandom) : 12'($urandom_range(0, lw));
		ky = ($urandom_range(0, 9) == 0) ? 12'($urandom) : 12'($urandom_range(0, lh));
		send(ghva_pkg::KIND_VOTE, m, kx, ky,
			($urandom_range(0, 7) == 0) ? 18'($urandom) : 18'($signed($urandom_range(0, 6400)) - 3200),
			($urandom_range(0, 7) == 0) ? 18'($urandom) : 18'($signed($urandom_range(0, 6400)) - 3200),
			lw, lh, 16'($urandom),
			($urandom_range(0, 9) == 0) ? 8'($urandom) : 8'($urandom_range(0, 4)),
			($urandom_range(0, 9) == 0) ? 8'($urandom) : 8'($urandom_range(0, 4)));
	endtask

	task automatic random_weights();
		for (int i = ghva_pkg::REG_WEIGHT_CENTER; i <= ghva_pkg::REG_WEIGHT_CORNER; i++)
			write_reg(ghva_pkg::reg_idx_t'(i), 16'($urandom));
	endtask

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > 6_000_000) begin
			$display("CHECK FAILED");
			$finish;
		end
	end

	always @(negedge clk) begin
		if (hold_rx && !rx_hold_done) begin
			out_stall <= 1'b1;
			repeat (3000) @(negedge clk);
			rx_hold_done <= 1'b1;
			out_stall <= 1'b0;
		end else if (!hold_rx) begin
			out_stall <= ($urandom_range(0, 9) < 3) ? 1'b1 : 1'b0;
		end else begin
			out_stall <= ($urandom_range(0, 29) == 0);
		end
	end

	initial begin
		logic [4:0] m;
		repeat (7) @(negedge clk);
		arst_n = 1'b1;
		write_reg(ghva_pkg::REG_WEIGHT_EDGE1, 16'h8000);
		write_reg(ghva_pkg::REG_WEIGHT_DIAG1, 16'h4000);
		write_reg(ghva_pkg::REG_WEIGHT_EDGE2, 16'h2000);
		write_reg(ghva_pkg::REG_WEIGHT_KNIGHT, 16'h1000);
		write_reg(ghva_pkg::REG_WEIGHT_CORNER, 16'h0800);
		send(ghva_pkg::KIND_QUERY, 5'd0, 0, 0, 0, 0, 1, 1, 0, 0, 0);
		send(ghva_pkg::KIND_VOTE, 5'd0, 12'd100, 12'd100, 18'sd0, 18'sd0, 12'd200, 12'd200,
			16'hFFFF, 8'd2, 8'd5);
		send(ghva_pkg::KIND_VOTE, 5'd31, 12'd0, 12'd0, 18'sd0, 18'sd0, 12'd0, 12'd0,
			16'hFFFF, 8'd0, 8'd0);
		send(ghva_pkg::KIND_VOTE, 5'd31, 12'd4095, 12'd4095, -18'sd131072, 18'sd131071,
			12'd4095, 12'd1, 16'h1234, 8'd255, 8'd0);
		send(ghva_pkg::KIND_VOTE, 5'd1, 12'd50, 12'd50, 18'sd8, -18'sd8, 12'd100, 12'd100,
			16'h1000, 8'd11, 8'd1);
		send(ghva_pkg::KIND_VOTE, 5'd1, 12'd30, 12'd70, 18'sd0, 18'sd0, 12'd100, 12'd100,
			16'h1000, 8'd1, 8'd1);
		send(ghva_pkg::KIND_VOTE, 5'd1, 12'd70, 12'd30, 18'sd0, 18'sd0, 12'd100, 12'd100,
			16'h1000, 8'd1, 8'd1);
		send(ghva_pkg::KIND_NONE, 5'd0, 0, 0, 0, 0, 1, 1, 16'hFFFF, 0, 0);
		send(ghva_pkg::KIND_QUERY, 5'd0, 0, 0, 0, 0, 1, 1, 0, 0, 0);
		send(ghva_pkg::KIND_QUERY, 5'd1, 0, 0, 0, 0, 1, 1, 0, 0, 0);
		send(ghva_pkg::KIND_QUERY, 5'd31, 0, 0, 0, 0, 1, 1, 0, 0, 0);
		for (int i = 0; i < 4; i++)
			send(ghva_pkg::KIND_VOTE, 5'd2, 12'd10, 12'd10, 0, 0, 12'd20, 12'd20,
				16'hFFFF, 8'd1, 8'd1);
		send(ghva_pkg::KIND_QUERY, 5'd2, 0, 0, 0, 0, 1, 1, 0, 0, 0);
		send(ghva_pkg::KIND_CLEAR, 5'd0, 0, 0, 0, 0, 1, 1, 0, 0, 0);
		send(ghva_pkg::KIND_QUERY, 5'd2, 0, 0, 0, 0, 1, 1, 0, 0, 0);
		drain();
		for (int ph = 0; ph < 6; ph++) begin
			case (ph)
				0: write_reg(ghva_pkg::REG_GRID_STEP, 16'd1);
				1: write_reg(ghva_pkg::REG_GRID_STEP, 16'd0);
				2: write_reg(ghva_pkg::REG_GRID_STEP, 16'd63);
				default: write_reg(ghva_pkg::REG_GRID_STEP, 16'($urandom_range(2, 32)));
			endcase
			write_reg(ghva_pkg::REG_BURST_LIMIT, (ph == 2) ? 16'hFFFF : (ph == 3) ? 16'd0 :
				16'($urandom_range(1, 20)));
			if (ph == 3)
				write_reg(ghva_pkg::REG_WEIGHT_CENTER, 16'd0);
			else
				random_weights();
			if (ph == 4)
				hold_rx = 1'b1;
			for (int n = 0; n < 135; n++) begin
				m = ($urandom_range(0, 3) == 0) ? 5'($urandom) : 5'($urandom_range(0, 3));
				case ($urandom_range(0, 39))
					0: send(ghva_pkg::KIND_CLEAR, m, 0, 0, 0, 0, 1, 1, 0, 0, 0);
					1: send(ghva_pkg::KIND_NONE, m, 12'($urandom), 0, 0, 0, 1, 1, 0, 0, 0);
					2, 3, 4, 5, 6, 7: send(ghva_pkg::KIND_QUERY, m, 0, 0, 0, 0, 1, 1, 0, 0, 0);
					default: random_vote(m);
				endcase
				if (n == 70) begin
					while (pending != 0)
						@(negedge clk);
				end
			end
			drain();
		end
		if (fail_count == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end
endmodule
